FILE: hw/rtl/ppct_pkg.sv
// ----------------------------------------------------------------------------
// ppct_pkg
// Shared types and constants of the pointer packet cursor tracker.
// ----------------------------------------------------------------------------
package ppct_pkg;

	// register indexes, byte address is 4*index
	localparam logic [1:0] REG_GAIN    = 2'd0;
	localparam logic [1:0] REG_X_LIMIT = 2'd1;
	localparam logic [1:0] REG_Y_LIMIT = 2'd2;
	localparam logic [1:0] REG_FORCE   = 2'd3;

	localparam logic [3:0]  GAIN_RST    = 4'd3;
	localparam logic [12:0] X_LIMIT_RST = 13'd1024;
	localparam logic [12:0] Y_LIMIT_RST = 13'd768;

	localparam int POS_X_RST = 640;
	localparam int POS_Y_RST = 360;

	// header byte bits
	localparam int HDR_LEFT  = 0;
	localparam int HDR_RIGHT = 1;
	localparam int HDR_SYNC  = 3;
	localparam int HDR_X_NEG = 4;
	localparam int HDR_Y_NEG = 5;
	localparam int HDR_X_OVF = 6;
	localparam int HDR_Y_OVF = 7;

	localparam int LIMIT_CAP  = 4096;
	localparam int FIFO_DEPTH = 2;

	typedef enum logic [2:0] {
		POS_HDR = 3'b001,
		POS_X   = 3'b010,
		POS_Y   = 3'b100
	} ppct_pos_t;

	// one complete, accepted packet
	typedef struct packed {
		logic       left;
		logic       right;
		logic       x_neg;
		logic       y_neg;
		logic [7:0] x_mag;
		logic [7:0] y_mag;
	} ppct_pkt_t;

endpackage

FILE: hw/rtl/ppct_ifs.sv
// ----------------------------------------------------------------------------
// ppct channel interfaces
// Valid/ready channels for received bytes and cursor results.
// ----------------------------------------------------------------------------
interface ppct_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ppct_cursor_if #(
	parameter int COORD_WIDTH = 12
);
	logic                   valid;
	logic                   ready;
	logic [COORD_WIDTH-1:0] cursor_x;
	logic [COORD_WIDTH-1:0] cursor_y;
	logic                   left_pressed;
	logic                   right_pressed;

	modport source (output valid, output cursor_x, output cursor_y,
		output left_pressed, output right_pressed, input ready);
	modport sink (input valid, input cursor_x, input cursor_y,
		input left_pressed, input right_pressed, output ready);
endinterface

FILE: hw/rtl/ppct_front.sv
// ----------------------------------------------------------------------------
// ppct_front
// Packet framing: collects three bytes, resyncs on the header sync bit and
// drops packets with an overflow flag.
// ----------------------------------------------------------------------------
module ppct_front
	import ppct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	ppct_byte_if.sink          rx,
	output logic               push,
	output ppct_pkt_t          push_pkt,
	input  logic               push_ready
);

	ppct_pos_t  pos_q;
	logic [7:0] hdr_q;
	logic [7:0] xb_q;
	logic       take;

	assign rx.ready = push_ready;
	assign take     = rx.valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HDR;
			hdr_q <= '0;
			xb_q  <= '0;
		end else if (take) begin
			case (pos_q)
				POS_HDR: begin
					if (rx.rx_byte[HDR_SYNC]) begin
						hdr_q <= rx.rx_byte;
						pos_q <= POS_X;
					end
				end
				POS_X: begin
					xb_q  <= rx.rx_byte;
					pos_q <= POS_Y;
				end
				default: begin
					pos_q <= POS_HDR;
				end
			endcase
		end
	end

	// third byte of a packet with no overflow
	assign push = take && (pos_q != POS_HDR) && (pos_q != POS_X)
		&& !hdr_q[HDR_X_OVF] && !hdr_q[HDR_Y_OVF];

	assign push_pkt.left  = hdr_q[HDR_LEFT];
	assign push_pkt.right = hdr_q[HDR_RIGHT];
	assign push_pkt.x_neg = hdr_q[HDR_X_NEG];
	assign push_pkt.y_neg = hdr_q[HDR_Y_NEG];
	assign push_pkt.x_mag = xb_q;
	assign push_pkt.y_mag = rx.rx_byte;

endmodule

FILE: hw/rtl/ppct_fifo.sv
// ----------------------------------------------------------------------------
// ppct_fifo
// Short packet queue between framing and cursor update.
// ----------------------------------------------------------------------------
module ppct_fifo
	import ppct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ppct_pkt_t push_pkt,
	output logic      push_ready,
	output logic      pop_valid,
	output ppct_pkt_t pop_pkt,
	input  logic      pop_ready
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	ppct_pkt_t       mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	logic            full;

	assign full       = (count_q == CW'(FIFO_DEPTH));
	assign push_ready = !full;
	assign pop_valid  = (count_q != '0);
	assign pop        = pop_valid && pop_ready;
	assign pop_pkt    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("ppct_fifo: push while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FIFO_DEPTH))
		else $error("ppct_fifo: count beyond depth");
	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (wr_ptr_q == rd_ptr_q))
		else $error("ppct_fifo: pointers apart while full");
`endif

endmodule

FILE: hw/rtl/ppct_back.sv
// ----------------------------------------------------------------------------
// ppct_back
// Cursor update: scales the motions by the gain, then moves and clamps the
// cursor and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ppct_back
	import ppct_pkg::*;
#(
	parameter int COORD_WIDTH = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pkt_valid,
	input  ppct_pkt_t     pkt,
	output logic          pkt_ready,
	input  logic [3:0]    gain,
	input  logic [12:0]   x_limit,
	input  logic [12:0]   y_limit,
	input  logic          force_left,
	ppct_cursor_if.source cursor
);

	localparam int CAP = (COORD_WIDTH > 12) ? LIMIT_CAP : (1 << COORD_WIDTH);
	localparam int SW  = COORD_WIDTH + 5;

	function automatic logic [12:0] limit_top(input logic [12:0] lim);
		logic [12:0] t;
		if (lim == '0) begin
			t = '0;
		end else if (lim > 13'(CAP)) begin
			t = 13'(CAP - 1);
		end else begin
			t = lim - 13'd1;
		end
		return t;
	endfunction

	logic signed [8:0]  mx;
	logic signed [8:0]  my;
	logic signed [5:0]  g;
	logic signed [14:0] prod_x;
	logic signed [14:0] prod_y;

	logic               valid_s1;
	logic signed [12:0] dx_s1;
	logic signed [12:0] dy_s1;
	logic               left_s1;
	logic               right_s1;

	logic                   out_valid_q;
	logic [COORD_WIDTH-1:0] pos_x_q;
	logic [COORD_WIDTH-1:0] pos_y_q;
	logic                   left_q;
	logic                   right_q;

	logic                 adv;
	logic signed [SW-1:0] pos_x_ext;
	logic signed [SW-1:0] pos_y_ext;
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [SW-1:0] top_x_ext;
	logic signed [SW-1:0] top_y_ext;
	logic [COORD_WIDTH-1:0] nx;
	logic [COORD_WIDTH-1:0] ny;

	// stage 1: signed 9-bit motions times gain
	assign mx     = {pkt.x_neg, pkt.x_mag};
	assign my     = {pkt.y_neg, pkt.y_mag};
	assign g      = {2'b00, gain};
	assign prod_x = mx * g;
	assign prod_y = my * g;

	assign adv       = valid_s1 && (!out_valid_q || cursor.ready);
	assign pkt_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_ready) begin
			valid_s1 <= pkt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_valid && pkt_ready) begin
			dx_s1    <= prod_x[12:0];
			dy_s1    <= prod_y[12:0];
			left_s1  <= pkt.left | force_left;
			right_s1 <= pkt.right;
		end
	end

	// stage 2: move and clamp
	assign pos_x_ext = SW'({1'b0, pos_x_q});
	assign pos_y_ext = SW'({1'b0, pos_y_q});
	assign top_x_ext = SW'({1'b0, limit_top(x_limit)});
	assign top_y_ext = SW'({1'b0, limit_top(y_limit)});
	assign sum_x     = pos_x_ext + SW'(dx_s1);
	assign sum_y     = pos_y_ext - SW'(dy_s1);

	always_comb begin
		if (sum_x < 0) begin
			nx = '0;
		end else if (sum_x > top_x_ext) begin
			nx = top_x_ext[COORD_WIDTH-1:0];
		end else begin
			nx = sum_x[COORD_WIDTH-1:0];
		end
		if (sum_y < 0) begin
			ny = '0;
		end else if (sum_y > top_y_ext) begin
			ny = top_y_ext[COORD_WIDTH-1:0];
		end else begin
			ny = sum_y[COORD_WIDTH-1:0];
		end
	end

	// the cursor registers are also the output payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_x_q     <= COORD_WIDTH'(POS_X_RST);
			pos_y_q     <= COORD_WIDTH'(POS_Y_RST);
			left_q      <= 1'b0;
			right_q     <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				pos_x_q     <= nx;
				pos_y_q     <= ny;
				left_q      <= left_s1;
				right_q     <= right_s1;
			end else if (cursor.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cursor.valid         = out_valid_q;
	assign cursor.cursor_x      = pos_x_q;
	assign cursor.cursor_y      = pos_y_q;
	assign cursor.left_pressed  = left_q;
	assign cursor.right_pressed = right_q;

`ifndef SYNTHESIS
	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (pos_x_ext <= top_x_ext))
		else $error("ppct_back: cursor x beyond limit");
	a_y_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (pos_y_ext <= top_y_ext))
		else $error("ppct_back: cursor y beyond limit");
	a_adv_shows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("ppct_back: advanced item not shown");
`endif

endmodule

FILE: hw/rtl/pointer_packet_cursor_tracker_unit.sv
// ----------------------------------------------------------------------------
// pointer_packet_cursor_tracker_unit
// Decodes three-byte pointing-device packets into a clamped cursor position.
// ----------------------------------------------------------------------------
// rx takes one received byte per item with a valid/ready handshake; cursor
// gives one item (x, y, left, right) for every packet that is framed and has
// no overflow flag. Header bytes without the sync bit are dropped.
// rx accepts one byte per cycle while the packet queue is not full. The result
// of a packet passes from the queue through the stage 1 registers into the
// cursor registers; the cursor update is a combinational add and clamp, so
// packets sustain one per cycle through the back end while cursor is ready.
// A two-entry packet queue sits between framing and the update stages; when
// the cursor receiver stalls, the update stages hold, the queue fills and
// rx.ready drops only once the queue is full.
// Registers over APB at 4*index: gain, x limit, y limit, left override.
// Reset clears framing and the queue, sets the cursor to 640,360 and loads
// the register defaults (gain 3, limits 1024 and 768, override off).
// ----------------------------------------------------------------------------
module pointer_packet_cursor_tracker_unit
	import ppct_pkg::*;
#(
	parameter int COORD_WIDTH = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	ppct_byte_if.sink     rx,
	ppct_cursor_if.source cursor
);

	logic [3:0]  gain_q;
	logic [12:0] x_limit_q;
	logic [12:0] y_limit_q;
	logic        force_q;
	logic        wr_en;

	logic      push;
	ppct_pkt_t push_pkt;
	logic      push_ready;
	logic      pop_valid;
	ppct_pkt_t pop_pkt;
	logic      pop_ready;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_RST;
			x_limit_q <= X_LIMIT_RST;
			y_limit_q <= Y_LIMIT_RST;
			force_q   <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_GAIN:    gain_q    <= pwdata[3:0];
				REG_X_LIMIT: x_limit_q <= pwdata[12:0];
				REG_Y_LIMIT: y_limit_q <= pwdata[12:0];
				REG_FORCE:   force_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GAIN:    prdata = {28'd0, gain_q};
			REG_X_LIMIT: prdata = {19'd0, x_limit_q};
			REG_Y_LIMIT: prdata = {19'd0, y_limit_q};
			REG_FORCE:   prdata = {31'd0, force_q};
			default:     prdata = '0;
		endcase
	end

	ppct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push       (push),
		.push_pkt   (push_pkt),
		.push_ready (push_ready)
	);

	ppct_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_pkt   (push_pkt),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_pkt    (pop_pkt),
		.pop_ready  (pop_ready)
	);

	ppct_back #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_valid  (pop_valid),
		.pkt        (pop_pkt),
		.pkt_ready  (pop_ready),
		.gain       (gain_q),
		.x_limit    (x_limit_q),
		.y_limit    (y_limit_q),
		.force_left (force_q),
		.cursor     (cursor)
	);

endmodule
